[rtl/bps_pkg.sv]
// Shared types and constants for the byte pattern search block.
`default_nettype none
package bps_pkg;

  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned RESULT_BITS = 32;

  // Item kinds on the input channel.
  localparam logic KIND_PATTERN  = 1'b0;
  localparam logic KIND_HAYSTACK = 1'b1;

  typedef logic [BYTE_BITS-1:0] byte_t;

  // Broadcast control from the top level to every cell of the chain.
  typedef struct packed {
    logic load;     // shift a pattern byte into the chain
    logic restart;  // this pattern byte opens a new pattern
    logic search;   // advance the partial-match flags with a haystack byte
    logic clear;    // drop all partial matches
  } bps_ctrl_t;

endpackage
`default_nettype wire

[rtl/byte_pattern_search.sv]
// Top level of the byte pattern search: control, counters and the chain of cells.
`default_nettype none
// Streams a haystack past a loaded byte pattern and reports the first match.
// One item is taken per clock cycle, pattern bytes and haystack bytes alike;
// a result appears in the output register in the cycle after the haystack byte
// that completes the match (or ends the haystack without one). The pattern
// sits in a chain of MAX_PATTERN cells, newest byte in the first cell; each
// haystack byte is compared in every cell at once and the partial-match flags
// move one cell toward the first cell per byte, so the first cell sees a full
// match. Input is stalled only while a result waits and the output side is
// not taking it.
module byte_pattern_search #(
  parameter int unsigned MAX_PATTERN  = 256,
  parameter int unsigned OFFSET_WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic                           kind,
  input  wire logic [bps_pkg::BYTE_BITS-1:0]  data_byte,
  input  wire logic                           last_byte,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic                           found,
  output      logic [bps_pkg::RESULT_BITS-1:0] match_offset
);
  import bps_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int unsigned CMP_W = (OFFSET_WIDTH > LEN_W) ? OFFSET_WIDTH : LEN_W;
  localparam int unsigned SUB_W = (CMP_W > RESULT_BITS) ? CMP_W : RESULT_BITS;

  logic [LEN_W-1:0]        pat_len;
  logic [LEN_W-1:0]        pat_len_next;
  logic                    overflow;
  logic                    overflow_next;
  logic                    complete;
  logic                    complete_next;
  logic [OFFSET_WIDTH-1:0] count;
  logic [OFFSET_WIDTH-1:0] count_next;
  logic [OFFSET_WIDTH-1:0] count_inc;
  logic                    reported;
  logic                    reported_next;
  logic                    out_valid_next;
  logic                    found_next;
  logic [RESULT_BITS-1:0]  offset_next;
  logic [SUB_W-1:0]        offset_full;

  logic                    accept;
  logic                    match;
  bps_ctrl_t               ctrl;

  byte_t                   cell_pat   [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]  cell_valid;
  logic [MAX_PATTERN-1:0]  cell_flag;
  logic [MAX_PATTERN-1:0]  cell_hit;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    count_inc = (count == {OFFSET_WIDTH{1'b1}}) ? count : count + 1'b1;
    match = (kind == KIND_HAYSTACK) && !reported && complete && !overflow &&
            cell_hit[0] &&
            (CMP_W'(count_inc) >= CMP_W'(pat_len));
    offset_full = SUB_W'(count_inc) - SUB_W'(pat_len);

    ctrl.load    = accept && (kind == KIND_PATTERN);
    ctrl.restart = complete;
    ctrl.search  = accept && (kind == KIND_HAYSTACK) && !reported;
    ctrl.clear   = accept && ((kind == KIND_PATTERN) || last_byte);

    pat_len_next   = pat_len;
    overflow_next  = overflow;
    complete_next  = complete;
    count_next     = count;
    reported_next  = reported;
    out_valid_next = out_valid && !out_ready;
    found_next     = found;
    offset_next    = match_offset;

    if (accept) begin
      if (kind == KIND_PATTERN) begin
        count_next    = '0;
        reported_next = 1'b0;
        complete_next = last_byte;
        if (complete) begin
          pat_len_next  = LEN_W'(1);
          overflow_next = 1'b0;
        end else if (pat_len < LEN_W'(MAX_PATTERN)) begin
          pat_len_next = pat_len + 1'b1;
        end else begin
          overflow_next = 1'b1;
        end
      end else if (reported) begin
        if (last_byte) begin
          count_next    = '0;
          reported_next = 1'b0;
        end
      end else begin
        count_next = count_inc;
        if (match) begin
          out_valid_next = 1'b1;
          found_next     = 1'b1;
          offset_next    = offset_full[RESULT_BITS-1:0];
          reported_next  = !last_byte;
        end else if (last_byte) begin
          out_valid_next = 1'b1;
          found_next     = 1'b0;
          offset_next    = '0;
        end
        if (last_byte) begin
          count_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len   <= '0;
      overflow  <= 1'b0;
      complete  <= 1'b1;
      count     <= '0;
      reported  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pat_len   <= pat_len_next;
      overflow  <= overflow_next;
      complete  <= complete_next;
      count     <= count_next;
      reported  <= reported_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    found        <= found_next;
    match_offset <= offset_next;
  end

  // Pattern bytes enter at cell 0 and move up; match flags move down to cell 0.
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    byte_t prev_pat;
    logic  prev_valid;
    logic  next_valid;
    logic  next_flag;

    if (k == 0) begin : g_head
      assign prev_pat   = data_byte;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_pat   = cell_pat[k-1];
      assign prev_valid = cell_valid[k-1];
    end

    if (k == MAX_PATTERN - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_flag  = 1'b0;
    end else begin : g_inner
      assign next_valid = cell_valid[k+1];
      assign next_flag  = cell_flag[k+1];
    end

    bps_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .first      (k == 0),
      .data_byte  (data_byte),
      .prev_pat   (prev_pat),
      .prev_valid (prev_valid),
      .next_valid (next_valid),
      .next_flag  (next_flag),
      .pat        (cell_pat[k]),
      .valid      (cell_valid[k]),
      .flag       (cell_flag[k]),
      .hit        (cell_hit[k])
    );
  end

endmodule
`default_nettype wire

[rtl/bps_cell.sv]
// One cell of the search chain: a pattern byte, its valid bit and a partial-match flag.
`default_nettype none
module bps_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bps_pkg::bps_ctrl_t ctrl,
  input  wire logic              first,
  input  wire bps_pkg::byte_t    data_byte,
  input  wire bps_pkg::byte_t    prev_pat,
  input  wire logic              prev_valid,
  input  wire logic              next_valid,
  input  wire logic              next_flag,
  output      bps_pkg::byte_t    pat,
  output      logic              valid,
  output      logic              flag,
  output      logic              hit
);
  import bps_pkg::*;

  logic valid_next;
  logic flag_next;

  // The cell holding the oldest pattern byte starts a match; the others extend
  // the partial match handed down from the cell above.
  always_comb begin
    hit = valid && (data_byte == pat) && (!next_valid || next_flag);

    valid_next = valid;
    if (ctrl.load) begin
      valid_next = prev_valid && (first || !ctrl.restart);
    end

    flag_next = flag;
    if (ctrl.clear) begin
      flag_next = 1'b0;
    end else if (ctrl.search) begin
      flag_next = hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      flag  <= 1'b0;
    end else begin
      valid <= valid_next;
      flag  <= flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      pat <= prev_pat;
    end
  end

endmodule
`default_nettype wire

[tb/sv/byte_pattern_search_tb.sv]
// Testbench for byte_pattern_search: directed and random streams checked by a predictor.
module byte_pattern_search_tb;
  import bps_pkg::*;

  localparam int unsigned PATTERN_SLOTS = 256;
  localparam int unsigned COUNT_BITS    = 32;
  localparam longint unsigned COUNT_TOP = (64'd1 << COUNT_BITS) - 64'd1;
  localparam int RANDOM_ITEMS = 600;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    logic                   hit;
    logic [RESULT_BITS-1:0] offset;
  } search_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   kind = KIND_PATTERN;
  byte_t                  data_byte = '0;
  logic                   last_byte = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   found;
  logic [RESULT_BITS-1:0] match_offset;

  // Predictor state.
  byte_t           pat_mem [PATTERN_SLOTS];
  int unsigned     pat_len;
  logic            pat_too_long;
  logic            pat_closed;
  byte_t           recent [PATTERN_SLOTS];
  longint unsigned hay_seen;
  logic            hit_sent;
  search_result_t  expected_hits[$];

  int error_count = 0;
  int cycle_count = 0;
  int items_sent  = 0;
  int in_mode     = 0;
  int out_mode    = 0;
  int out_stall_left = 0;

  byte_pattern_search i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .match_offset (match_offset)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("byte_pattern_search verification failed");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one; mode 0 means no idling at all.
  function automatic int pick_gap(input int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0 || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  function automatic void drop_haystack();
    int i;
    for (i = 0; i < PATTERN_SLOTS; i++) recent[i] = '0;
    hay_seen = 0;
    hit_sent = 1'b0;
  endfunction

  function automatic void clear_search_model();
    int i;
    for (i = 0; i < PATTERN_SLOTS; i++) pat_mem[i] = '0;
    pat_len      = 0;
    pat_too_long = 1'b0;
    pat_closed   = 1'b1;
    drop_haystack();
  endfunction

  function automatic logic window_holds_pattern();
    int i;
    if (!pat_closed || pat_too_long || pat_len == 0) return 1'b0;
    if (hay_seen < longint'(pat_len)) return 1'b0;
    for (i = 0; i < pat_len; i++)
      if (pat_mem[i] != recent[pat_len - 1 - i]) return 1'b0;
    return 1'b1;
  endfunction

  // Advances the search state by one accepted item and queues any result it causes.
  function automatic void advance_search(input logic k, input byte_t d, input logic l);
    int i;
    search_result_t res;
    if (k == KIND_PATTERN) begin
      drop_haystack();
      if (pat_closed) begin
        pat_len      = 0;
        pat_too_long = 1'b0;
        pat_closed   = 1'b0;
      end
      if (pat_len < PATTERN_SLOTS) begin
        pat_mem[pat_len] = d;
        pat_len++;
      end else begin
        pat_too_long = 1'b1;
      end
      if (l) pat_closed = 1'b1;
    end else if (hit_sent) begin
      if (l) drop_haystack();
    end else begin
      for (i = PATTERN_SLOTS - 1; i > 0; i--) recent[i] = recent[i - 1];
      recent[0] = d;
      if (hay_seen < COUNT_TOP) hay_seen++;
      if (window_holds_pattern()) begin
        res.hit    = 1'b1;
        res.offset = RESULT_BITS'(hay_seen - longint'(pat_len));
        expected_hits.push_back(res);
        if (l) drop_haystack();
        else hit_sent = 1'b1;
      end else if (l) begin
        res.hit    = 1'b0;
        res.offset = '0;
        expected_hits.push_back(res);
        drop_haystack();
      end
    end
  endfunction

  // Called at a rising edge; returns at the edge where the item is taken.
  task automatic send_item(input logic k, input byte_t d, input logic l);
    int gap;
    gap = pick_gap(in_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    data_byte <= d;
    last_byte <= l;
    do @(posedge clk); while (!in_ready);
    advance_search(k, d, l);
    items_sent++;
  endtask

  task automatic send_bytes(input logic k, input byte_t seq[$], input logic close);
    int i;
    for (i = 0; i < seq.size(); i++)
      send_item(k, seq[i], close && (i == seq.size() - 1));
  endtask

  task automatic set_idling(input int in_m, input int out_m);
    in_mode  = in_m;
    out_mode = out_m;
  endtask

  always @(posedge clk) begin
    if (out_stall_left > 0) begin
      out_ready <= 1'b0;
      out_stall_left = out_stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (out_mode != 0 && $urandom_range(0, 4) == 0) out_stall_left = pick_gap(1);
    end
  end

  always @(posedge clk) begin
    search_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_hits.size() == 0) begin
        flag_error($sformatf("unexpected result found=%0b offset=%0d", found, match_offset));
      end else begin
        want = expected_hits.pop_front();
        if (found !== want.hit)
          flag_error($sformatf("found: got %0b, want %0b", found, want.hit));
        if (match_offset !== want.offset)
          flag_error($sformatf("match_offset: got %0d, want %0d", match_offset, want.offset));
      end
    end
  end

  // No pattern loaded yet: every haystack must end without a match.
  task automatic test_empty_pattern();
    set_idling(0, 0);
    send_item(KIND_HAYSTACK, 8'h00, 1'b0);
    send_item(KIND_HAYSTACK, 8'hFF, 1'b1);
    send_item(KIND_HAYSTACK, 8'h5A, 1'b1);
  endtask

  task automatic test_basic_match();
    set_idling(1, 1);
    send_bytes(KIND_PATTERN, '{8'h00, 8'hFF}, 1'b1);
    // Match at offset 2; the bytes after it, the closing one included, stay silent.
    send_bytes(KIND_HAYSTACK, '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF}, 1'b1);
    // Match on the haystack's final byte.
    send_bytes(KIND_HAYSTACK, '{8'h00, 8'hFF}, 1'b1);
    send_item(KIND_HAYSTACK, 8'hFF, 1'b1);
    send_item(KIND_PATTERN, 8'hA5, 1'b1);
    send_item(KIND_HAYSTACK, 8'hA5, 1'b1);
  endtask

  // Haystack bytes during an open pattern load never match, and the load carries on.
  task automatic test_incomplete_pattern();
    set_idling(0, 1);
    send_item(KIND_PATTERN, 8'h12, 1'b0);
    send_item(KIND_HAYSTACK, 8'h12, 1'b1);
    send_item(KIND_PATTERN, 8'h34, 1'b1);
    send_bytes(KIND_HAYSTACK, '{8'h12, 8'h34}, 1'b1);
  endtask

  // A pattern byte in the middle of a haystack drops it without a result.
  task automatic test_aborted_haystack();
    set_idling(1, 0);
    send_bytes(KIND_HAYSTACK, '{8'h77, 8'h12}, 1'b0);
    send_item(KIND_PATTERN, 8'h77, 1'b1);
    send_item(KIND_HAYSTACK, 8'h77, 1'b1);
  endtask

  task automatic test_long_pattern();
    byte_t pat[$];
    byte_t hay[$];
    int i;
    set_idling(1, 1);
    // One byte past capacity: the pattern is flagged and can never match.
    for (i = 0; i < PATTERN_SLOTS + 1; i++) pat.push_back(byte_t'($urandom_range(0, 255)));
    send_bytes(KIND_PATTERN, pat, 1'b1);
    for (i = 0; i < PATTERN_SLOTS; i++) hay.push_back(pat[i]);
    send_bytes(KIND_HAYSTACK, hay, 1'b1);
    // A pattern that fills the store exactly still matches.
    pat.delete();
    for (i = 0; i < PATTERN_SLOTS; i++) pat.push_back(byte_t'($urandom_range(0, 255)));
    send_bytes(KIND_PATTERN, pat, 1'b1);
    hay.delete();
    hay.push_back(8'h00);
    hay.push_back(8'hFF);
    for (i = 0; i < PATTERN_SLOTS; i++) hay.push_back(pat[i]);
    hay.push_back(8'h3C);
    send_bytes(KIND_HAYSTACK, hay, 1'b1);
  endtask

  task automatic test_random_streams();
    byte_t pat[$];
    byte_t hay[$];
    byte_t alpha[4];
    int start, nsym, len, n_hay, h, i, pos, choice;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      set_idling($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
      for (i = 0; i < 4; i++) alpha[i] = byte_t'($urandom_range(0, 255));
      nsym   = $urandom_range(2, 4);
      choice = $urandom_range(0, 9);
      pat.delete();
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 24) : $urandom_range(1, 5);
      for (i = 0; i < len; i++) pat.push_back(alpha[$urandom_range(0, nsym - 1)]);
      if (choice == 0) begin
        // Noise: fully random items.
        repeat ($urandom_range(1, 8))
          send_item(logic'($urandom_range(0, 1)), byte_t'($urandom_range(0, 255)),
                    logic'($urandom_range(0, 1)));
      end else begin
        if (choice == 1 && len > 1) begin
          // Pattern load split by haystack bytes.
          pos = $urandom_range(1, len - 1);
          for (i = 0; i < pos; i++) send_item(KIND_PATTERN, pat[i], 1'b0);
          repeat ($urandom_range(1, 3))
            send_item(KIND_HAYSTACK, alpha[$urandom_range(0, nsym - 1)],
                      logic'($urandom_range(0, 1)));
          for (i = pos; i < len; i++) send_item(KIND_PATTERN, pat[i], i == len - 1);
        end else begin
          send_bytes(KIND_PATTERN, pat, 1'b1);
        end
        n_hay = $urandom_range(1, 3);
        for (h = 0; h < n_hay; h++) begin
          hay.delete();
          len = $urandom_range(1, 30);
          for (i = 0; i < len; i++) hay.push_back(alpha[$urandom_range(0, nsym - 1)]);
          if ($urandom_range(0, 1) == 1 && pat.size() <= len) begin
            pos = $urandom_range(0, len - pat.size());
            for (i = 0; i < pat.size(); i++) hay[pos + i] = pat[i];
          end
          // An unclosed haystack runs into the next one or is cut off by a pattern byte.
          send_bytes(KIND_HAYSTACK, hay, $urandom_range(0, 9) != 0);
        end
      end
    end
  endtask

  initial begin
    clear_search_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_empty_pattern();
    test_basic_match();
    test_incomplete_pattern();
    test_aborted_haystack();
    test_long_pattern();
    test_random_streams();
    in_valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("byte_pattern_search verification clean");
    end else begin
      $display("byte_pattern_search verification failed");
    end
    $finish;
  end

endmodule
